@@ rtl/core/hlec_pkg.sv @@
// Package with the constants, types and codes shared by the entry cache.
package hlec_pkg;

  // Cache geometry; both sizes are powers of two.
  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned BUCKETS = 1024;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned LINK_W  = IDX_W + 1;

  // A link equal to the entry count marks the end of a list.
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(ENTRIES);

  localparam logic [32:0] SPRITE_LIMIT = 33'd131072;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [15:0] CHAIN_LIMIT_RST = 16'd1100;

  // Result codes.
  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_RESERVED = 3'd4,
    ST_ILLEGAL  = 3'd5,
    ST_CHAINLIM = 3'd6
  } status_e;

  // Preload codes.
  localparam logic [1:0] PRE_RESERVE = 2'd1;

  // Kind of update in flight.
  typedef enum logic {
    JOB_HIT,
    JOB_MISS
  } job_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_BH_RD,
    S_HEAD,
    S_WALK,
    S_CMP,
    S_SLOT,
    S_LRU_RD,
    S_LRU_A,
    S_LRU_B,
    S_LRU_C,
    S_LRU_D,
    S_UL_RD,
    S_UL_A,
    S_UL_B,
    S_KEYWR,
    S_PUSH_RD,
    S_PUSH_A,
    S_PUSH_B,
    S_FIN
  } state_e;

  // Full key of one entry.
  typedef struct packed {
    logic [31:0] sprite;
    logic [39:0] lights;
    logic [63:0] tint;
    logic [63:0] palette;
  } key_t;

endpackage

@@ rtl/core/hashed_lru_entry_cache.sv @@
// Hashed LRU entry cache: FNV-1a bucket selection, chained buckets, LRU refill.
//
// Each request beat carries a full sprite key. The key is hashed with FNV-1a
// over the sprite word and the five light bytes, one multiply per cycle, and
// the bucket chain is then walked in the entry memories, each link passing
// through a walk and a compare state since every link is a registered memory
// read. A hit or a miss then relinks the LRU list and the bucket chain. One
// request is worked on at a time, and the next one is taken while the
// previous result still waits in the output register. After reset a clearing
// pass initialises the link memories; no request is accepted during it,
// though the chain limit may be written.
module hashed_lru_entry_cache (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  // Request channel
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [31:0]  sprite_i,
  input  logic [39:0]  light_word_i,
  input  logic [63:0]  tint_word_i,
  input  logic [63:0]  palette_word_i,
  input  logic         check_only_i,
  input  logic [1:0]   preload_i,
  // Result channel
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [2:0]   status_o,
  output logic [9:0]   entry_index_o,
  output logic         evicted_live_o,
  output logic [15:0]  chain_steps_o
);

  localparam int unsigned IW = hlec_pkg::IDX_W;
  localparam int unsigned LW = hlec_pkg::LINK_W;
  localparam int unsigned BW = hlec_pkg::BKT_W;

  // Memories.
  hlec_pkg::key_t  key_mem    [hlec_pkg::ENTRIES];
  logic            use_mem    [hlec_pkg::ENTRIES];
  logic [BW-1:0]   bkt_mem    [hlec_pkg::ENTRIES];
  logic [LW-1:0]   lprev_mem  [hlec_pkg::ENTRIES];
  logic [LW-1:0]   lnext_mem  [hlec_pkg::ENTRIES];
  logic [LW-1:0]   cprev_mem  [hlec_pkg::ENTRIES];
  logic [LW-1:0]   cnext_mem  [hlec_pkg::ENTRIES];
  logic [LW-1:0]   bh_mem     [hlec_pkg::BUCKETS];

  // Read ports and registered read data.
  logic [IW-1:0]   ent_ra;
  logic [BW-1:0]   bh_ra;
  hlec_pkg::key_t  key_rd_q;
  logic            use_rd_q;
  logic [BW-1:0]   bkt_rd_q;
  logic [LW-1:0]   lprev_rd_q, lnext_rd_q, cprev_rd_q, cnext_rd_q, bh_rd_q;

  // Write ports.
  logic            key_we, use_we, bkt_we, lprev_we, lnext_we, cprev_we, cnext_we, bh_we;
  logic [IW-1:0]   key_wa, use_wa, bkt_wa, lprev_wa, lnext_wa, cprev_wa, cnext_wa;
  logic [BW-1:0]   bh_wa;
  logic            use_wd;
  logic [LW-1:0]   lprev_wd, lnext_wd, cprev_wd, cnext_wd, bh_wd;

  // Sequencer and working registers.
  hlec_pkg::state_e state_q, state_d;
  hlec_pkg::job_e   job_q, job_d;
  logic [IW-1:0]    clr_q, clr_d;
  hlec_pkg::key_t   key_q, key_d;
  logic             chk_q, chk_d;
  logic [1:0]       pre_q, pre_d;
  logic [31:0]      hash_q, hash_d;
  logic [2:0]       hcnt_q, hcnt_d;
  logic [BW-1:0]    bkt_q, bkt_d;
  logic [BW-1:0]    ubk_q, ubk_d;
  logic [LW-1:0]    cur_q, cur_d;
  logic [IW-1:0]    tgt_q, tgt_d;
  logic [LW-1:0]    p_q, p_d, n_q, n_d;
  logic [LW-1:0]    lru_head_q, lru_head_d, lru_tail_q, lru_tail_d;
  logic [15:0]      limit_q;
  hlec_pkg::status_e res_st_q, res_st_d;
  logic [IW-1:0]    res_idx_q, res_idx_d;
  logic             res_ev_q, res_ev_d;
  logic [15:0]      steps_q, steps_d;
  logic             out_valid_q, out_valid_d;
  logic [2:0]       out_st_q;
  logic [9:0]       out_idx_q;
  logic             out_ev_q;
  logic [15:0]      out_steps_q;
  logic             out_load;

  logic [31:0]      hash_prod;
  logic [7:0]       hash_byte;
  logic [LW-1:0]    tgt_link;

  assign tgt_link  = {1'b0, tgt_q};
  assign hash_prod = hash_q * hlec_pkg::FNV_PRIME;

  // Light byte folded in after each multiply, top light byte first.
  always_comb begin
    case (hcnt_q)
      3'd0:    hash_byte = key_q.lights[39:32];
      3'd1:    hash_byte = key_q.lights[31:24];
      3'd2:    hash_byte = key_q.lights[23:16];
      3'd3:    hash_byte = key_q.lights[15:8];
      default: hash_byte = key_q.lights[7:0];
    endcase
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    if (key_we)   key_mem[key_wa]     <= key_q;
    if (use_we)   use_mem[use_wa]     <= use_wd;
    if (bkt_we)   bkt_mem[bkt_wa]     <= bkt_q;
    if (lprev_we) lprev_mem[lprev_wa] <= lprev_wd;
    if (lnext_we) lnext_mem[lnext_wa] <= lnext_wd;
    if (cprev_we) cprev_mem[cprev_wa] <= cprev_wd;
    if (cnext_we) cnext_mem[cnext_wa] <= cnext_wd;
    if (bh_we)    bh_mem[bh_wa]       <= bh_wd;
  end

  // Memory reads, registered.
  always_ff @(posedge clk_i) begin
    key_rd_q   <= key_mem[ent_ra];
    use_rd_q   <= use_mem[ent_ra];
    bkt_rd_q   <= bkt_mem[ent_ra];
    lprev_rd_q <= lprev_mem[ent_ra];
    lnext_rd_q <= lnext_mem[ent_ra];
    cprev_rd_q <= cprev_mem[ent_ra];
    cnext_rd_q <= cnext_mem[ent_ra];
    bh_rd_q    <= bh_mem[bh_ra];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hlec_pkg::S_CLEAR;
      clr_q       <= '0;
      lru_head_q  <= '0;
      lru_tail_q  <= LW'(hlec_pkg::ENTRIES - 1);
      limit_q     <= hlec_pkg::CHAIN_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lru_head_q  <= lru_head_d;
      lru_tail_q  <= lru_tail_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    key_q     <= key_d;
    chk_q     <= chk_d;
    pre_q     <= pre_d;
    hash_q    <= hash_d;
    hcnt_q    <= hcnt_d;
    bkt_q     <= bkt_d;
    ubk_q     <= ubk_d;
    cur_q     <= cur_d;
    tgt_q     <= tgt_d;
    p_q       <= p_d;
    n_q       <= n_d;
    res_st_q  <= res_st_d;
    res_idx_q <= res_idx_d;
    res_ev_q  <= res_ev_d;
    steps_q   <= steps_d;
    if (out_load) begin
      out_st_q    <= res_st_q;
      out_idx_q   <= 10'(res_idx_q);
      out_ev_q    <= res_ev_q;
      out_steps_q <= steps_q;
    end
  end

  // Sequencer: next state, memory accesses and list updates.
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    clr_d      = clr_q;
    key_d      = key_q;
    chk_d      = chk_q;
    pre_d      = pre_q;
    hash_d     = hash_q;
    hcnt_d     = hcnt_q;
    bkt_d      = bkt_q;
    ubk_d      = ubk_q;
    cur_d      = cur_q;
    tgt_d      = tgt_q;
    p_d        = p_q;
    n_d        = n_q;
    lru_head_d = lru_head_q;
    lru_tail_d = lru_tail_q;
    res_st_d   = res_st_q;
    res_idx_d  = res_idx_q;
    res_ev_d   = res_ev_q;
    steps_d    = steps_q;
    out_load   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o = 1'b1;

    ent_ra   = tgt_q;
    bh_ra    = bkt_q;
    key_we   = 1'b0; key_wa   = tgt_q;
    use_we   = 1'b0; use_wa   = tgt_q; use_wd = 1'b1;
    bkt_we   = 1'b0; bkt_wa   = tgt_q;
    lprev_we = 1'b0; lprev_wa = tgt_q; lprev_wd = hlec_pkg::NO_LINK;
    lnext_we = 1'b0; lnext_wa = tgt_q; lnext_wd = hlec_pkg::NO_LINK;
    cprev_we = 1'b0; cprev_wa = tgt_q; cprev_wd = hlec_pkg::NO_LINK;
    cnext_we = 1'b0; cnext_wa = tgt_q; cnext_wd = hlec_pkg::NO_LINK;
    bh_we    = 1'b0; bh_wa    = bkt_q; bh_wd    = hlec_pkg::NO_LINK;

    unique case (state_q)
      // Initialise the link memories, one entry per cycle.
      hlec_pkg::S_CLEAR: begin
        use_we   = 1'b1; use_wa   = clr_q; use_wd = 1'b0;
        lprev_we = 1'b1; lprev_wa = clr_q;
        lprev_wd = (clr_q == '0) ? hlec_pkg::NO_LINK : LW'(clr_q) - LW'(1);
        lnext_we = 1'b1; lnext_wa = clr_q;
        lnext_wd = (clr_q == IW'(hlec_pkg::ENTRIES - 1)) ? hlec_pkg::NO_LINK
                                                          : LW'(clr_q) + LW'(1);
        cprev_we = 1'b1; cprev_wa = clr_q;
        cnext_we = 1'b1; cnext_wa = clr_q;
        bh_we    = 1'b1; bh_wa    = BW'(clr_q);
        clr_d    = clr_q + IW'(1);
        if (clr_q == IW'(hlec_pkg::ENTRIES - 1)) state_d = hlec_pkg::S_IDLE;
      end

      // Take a request beat.
      hlec_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          key_d     = '{sprite: sprite_i, lights: light_word_i,
                        tint: tint_word_i, palette: palette_word_i};
          chk_d     = check_only_i;
          pre_d     = preload_i;
          hash_d    = hlec_pkg::FNV_BASIS ^ sprite_i;
          hcnt_d    = '0;
          steps_d   = '0;
          res_idx_d = '0;
          res_ev_d  = 1'b0;
          if ({1'b0, sprite_i} >= hlec_pkg::SPRITE_LIMIT) begin
            res_st_d = hlec_pkg::ST_ILLEGAL;
            state_d  = hlec_pkg::S_FIN;
          end else begin
            state_d  = hlec_pkg::S_HASH;
          end
        end
      end

      // One FNV-1a round per cycle.
      hlec_pkg::S_HASH: begin
        if (hcnt_q == 3'd5) begin
          bkt_d   = hash_prod[BW-1:0];
          state_d = hlec_pkg::S_BH_RD;
        end else begin
          hash_d  = hash_prod ^ {24'd0, hash_byte};
          hcnt_d  = hcnt_q + 3'd1;
        end
      end

      hlec_pkg::S_BH_RD: begin
        state_d = hlec_pkg::S_HEAD;
      end

      hlec_pkg::S_HEAD: begin
        cur_d   = bh_rd_q;
        state_d = hlec_pkg::S_WALK;
      end

      // Follow the chain up to the step limit; at its end refill, unless only checking.
      hlec_pkg::S_WALK: begin
        ent_ra = cur_q[IW-1:0];
        if (cur_q == hlec_pkg::NO_LINK) begin
          if (chk_q) begin
            res_st_d = hlec_pkg::ST_ABSENT;
            state_d  = hlec_pkg::S_FIN;
          end else if (lru_tail_q == hlec_pkg::NO_LINK) begin
            res_st_d = hlec_pkg::ST_CHAINLIM;
            state_d  = hlec_pkg::S_FIN;
          end else begin
            ent_ra   = lru_tail_q[IW-1:0];
            tgt_d    = lru_tail_q[IW-1:0];
            job_d    = hlec_pkg::JOB_MISS;
            state_d  = hlec_pkg::S_SLOT;
          end
        end else if (steps_q >= limit_q) begin
          res_st_d = hlec_pkg::ST_CHAINLIM;
          state_d  = hlec_pkg::S_FIN;
        end else begin
          state_d  = hlec_pkg::S_CMP;
        end
      end

      // Compare the full key of the current link.
      hlec_pkg::S_CMP: begin
        if (use_rd_q && (key_rd_q == key_q)) begin
          if (chk_q) begin
            res_st_d = hlec_pkg::ST_PRESENT;
            state_d  = hlec_pkg::S_FIN;
          end else if (pre_q == hlec_pkg::PRE_RESERVE) begin
            res_st_d = hlec_pkg::ST_RESERVED;
            state_d  = hlec_pkg::S_FIN;
          end else begin
            tgt_d     = cur_q[IW-1:0];
            res_idx_d = cur_q[IW-1:0];
            res_st_d  = hlec_pkg::ST_HIT;
            job_d     = hlec_pkg::JOB_HIT;
            state_d   = hlec_pkg::S_LRU_RD;
          end
        end else begin
          cur_d   = cnext_rd_q;
          steps_d = steps_q + 16'd1;
          state_d = hlec_pkg::S_WALK;
        end
      end

      // Victim entry read back: unlink it if it still holds a key.
      hlec_pkg::S_SLOT: begin
        res_ev_d  = use_rd_q;
        res_idx_d = tgt_q;
        res_st_d  = hlec_pkg::ST_INSERTED;
        ubk_d     = bkt_rd_q;
        state_d   = use_rd_q ? hlec_pkg::S_UL_RD : hlec_pkg::S_KEYWR;
      end

      // Move the target to the front of the LRU list.
      hlec_pkg::S_LRU_RD: begin
        if (tgt_link == lru_head_q) begin
          if (job_q == hlec_pkg::JOB_HIT) begin
            ubk_d   = bkt_q;
            state_d = hlec_pkg::S_UL_RD;
          end else begin
            state_d = hlec_pkg::S_FIN;
          end
        end else begin
          state_d = hlec_pkg::S_LRU_A;
        end
      end

      hlec_pkg::S_LRU_A: begin
        p_d = lprev_rd_q;
        n_d = lnext_rd_q;
        if (lprev_rd_q != hlec_pkg::NO_LINK) begin
          lnext_we = 1'b1;
          lnext_wa = lprev_rd_q[IW-1:0];
          lnext_wd = lnext_rd_q;
        end
        state_d = hlec_pkg::S_LRU_B;
      end

      hlec_pkg::S_LRU_B: begin
        if (n_q != hlec_pkg::NO_LINK) begin
          lprev_we = 1'b1;
          lprev_wa = n_q[IW-1:0];
          lprev_wd = p_q;
        end else begin
          lru_tail_d = p_q;
        end
        state_d = hlec_pkg::S_LRU_C;
      end

      hlec_pkg::S_LRU_C: begin
        lprev_we = 1'b1;
        lnext_we = 1'b1;
        lnext_wd = lru_head_q;
        state_d  = hlec_pkg::S_LRU_D;
      end

      hlec_pkg::S_LRU_D: begin
        if (lru_head_q != hlec_pkg::NO_LINK) begin
          lprev_we = 1'b1;
          lprev_wa = lru_head_q[IW-1:0];
          lprev_wd = tgt_link;
        end
        lru_head_d = tgt_link;
        if (job_q == hlec_pkg::JOB_HIT) begin
          ubk_d   = bkt_q;
          state_d = hlec_pkg::S_UL_RD;
        end else begin
          state_d = hlec_pkg::S_FIN;
        end
      end

      // Take the target out of its chain.
      hlec_pkg::S_UL_RD: begin
        state_d = hlec_pkg::S_UL_A;
      end

      hlec_pkg::S_UL_A: begin
        p_d = cprev_rd_q;
        n_d = cnext_rd_q;
        if (cprev_rd_q != hlec_pkg::NO_LINK) begin
          cnext_we = 1'b1;
          cnext_wa = cprev_rd_q[IW-1:0];
          cnext_wd = cnext_rd_q;
        end else begin
          bh_we = 1'b1;
          bh_wa = ubk_q;
          bh_wd = cnext_rd_q;
        end
        state_d = hlec_pkg::S_UL_B;
      end

      hlec_pkg::S_UL_B: begin
        if (n_q != hlec_pkg::NO_LINK) begin
          cprev_we = 1'b1;
          cprev_wa = n_q[IW-1:0];
          cprev_wd = p_q;
        end
        state_d = (job_q == hlec_pkg::JOB_HIT) ? hlec_pkg::S_PUSH_RD : hlec_pkg::S_KEYWR;
      end

      // Refill the victim with the new key.
      hlec_pkg::S_KEYWR: begin
        key_we  = 1'b1;
        use_we  = 1'b1;
        bkt_we  = 1'b1;
        state_d = hlec_pkg::S_PUSH_RD;
      end

      // Put the target at the head of its bucket chain.
      hlec_pkg::S_PUSH_RD: begin
        state_d = hlec_pkg::S_PUSH_A;
      end

      hlec_pkg::S_PUSH_A: begin
        n_d = bh_rd_q;
        if (bh_rd_q != hlec_pkg::NO_LINK) begin
          cprev_we = 1'b1;
          cprev_wa = bh_rd_q[IW-1:0];
          cprev_wd = tgt_link;
        end
        state_d = hlec_pkg::S_PUSH_B;
      end

      hlec_pkg::S_PUSH_B: begin
        cprev_we = 1'b1;
        cnext_we = 1'b1;
        cnext_wd = n_q;
        bh_we    = 1'b1;
        bh_wd    = tgt_link;
        state_d  = (job_q == hlec_pkg::JOB_HIT) ? hlec_pkg::S_FIN : hlec_pkg::S_LRU_RD;
      end

      // Hand the result to the output register once it is free.
      hlec_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = hlec_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = hlec_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign entry_index_o  = out_idx_q;
  assign evicted_live_o = out_ev_q;
  assign chain_steps_o  = out_steps_q;

endmodule
